// ----- sv/fos_pkg.sv -----
// shared types and constants for the function output sequencer
`timescale 1ns / 1ps
`default_nettype none
package fos_pkg;
  localparam logic [1:0] CMD_PACKET = 2'd0;
  localparam logic [1:0] CMD_CV = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam logic [2:0] MODE_ONOFF = 3'd0;
  localparam logic [2:0] MODE_BLINK = 3'd1;
  localparam logic [2:0] MODE_SERVO = 3'd2;
  localparam logic [2:0] MODE_PAIR = 3'd3;
  localparam logic [2:0] MODE_MAX = 3'd7;

  localparam logic [2:0] CV_MODE = 3'd0;
  localparam logic [2:0] CV_RATE = 3'd1;
  localparam logic [2:0] CV_START = 3'd2;
  localparam logic [2:0] CV_END = 3'd3;

  localparam logic [7:0] GRP_MASK = 8'hE0;
  localparam logic [7:0] GRP_F0 = 8'h80;
  localparam logic [7:0] GRP_F5 = 8'hA0;
  localparam logic [7:0] FB_F13 = 8'hDE;
  localparam logic [7:0] FB_F21 = 8'hDF;
  localparam logic [7:0] NIB_MASK = 8'h0F;

  localparam int NFUNCS = 29;
  localparam int MAX_SERVO_WRITES = 3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PACKET,
    OP_CV,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t op;
    logic [28:0] nb;
    logic [4:0] lo;
    logic [4:0] hi;
    logic [7:0] cv_o;
    logic [2:0] cv_k;
    logic [7:0] cv_data;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_STATUS
  } state_t;

  function automatic logic [2:0] dflt_mode(input int i);
    case (i)
      0, 1, 2, 3: dflt_mode = MODE_SERVO;
      8, 9: dflt_mode = MODE_BLINK;
      10: dflt_mode = MODE_PAIR;
      default: dflt_mode = MODE_ONOFF;
    endcase
  endfunction

  function automatic logic [7:0] dflt_start(input int i);
    case (i)
      0, 1, 2, 3, 4, 5, 7: dflt_start = 8'd28;
      8, 9, 10, 11, 12: dflt_start = 8'd1;
      default: dflt_start = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] dflt_end(input int i);
    if (i < 8) dflt_end = 8'd140;
    else if (i < 12) dflt_end = 8'd50;
    else if (i == 12) dflt_end = 8'd4;
    else dflt_end = 8'd0;
  endfunction
endpackage
`default_nettype wire

// ----- sv/fos_front.sv -----
// front end: accepts words, decodes packet group and cv slot
`timescale 1ns / 1ps
`default_nettype none
module fos_front import fos_pkg::*; (
  input wire clk,
  input wire rst,
  input wire in_valid,
  output logic in_ready,
  input wire [1:0] cmd,
  input wire [7:0] func_byte,
  input wire [7:0] ext_byte,
  input wire [7:0] cv_number,
  input wire [7:0] cv_data,
  output logic q_valid,
  input wire q_ready,
  output job_t q_job
);
  localparam int QD = 2;
  job_t q [QD];
  logic [0:0] wp, rp;
  logic [1:0] cnt;
  job_t j;
  logic [7:0] off;
  logic [7:0] g;
  logic [15:0] prod;
  logic [7:0] quo;
  logic [7:0] rem;

  always_comb begin
    j = '0;
    g = func_byte & GRP_MASK;
    off = cv_number - 8'd30;
    // divide by five through a reciprocal multiply
    prod = 16'(off) * 16'd205;
    quo = {2'b00, prod[15:10]};
    rem = off - {quo[5:0], 2'b00} - quo;
    case (cmd)
      CMD_PACKET: begin
        j.op = OP_PACKET;
        if (g == GRP_F0) begin
          j.nb = {24'd0, func_byte[3:0], func_byte[4]};
          j.lo = 5'd0; j.hi = 5'd4;
        end else if (g == GRP_F5) begin
          if (func_byte[4]) begin
            j.nb = {20'd0, func_byte[3:0], 5'd0};
            j.lo = 5'd5; j.hi = 5'd8;
          end else begin
            j.nb = {16'd0, func_byte[3:0], 9'd0};
            j.lo = 5'd9; j.hi = 5'd12;
          end
        end else if (func_byte == FB_F13) begin
          j.nb = {8'd0, ext_byte, 13'd0};
          j.lo = 5'd13; j.hi = 5'd20;
        end else if (func_byte == FB_F21) begin
          j.nb = {ext_byte, 21'd0};
          j.lo = 5'd21; j.hi = 5'd28;
        end else begin
          j.op = OP_NONE;
        end
      end
      CMD_CV: begin
        j.op = (cv_number < 8'd30) ? OP_NONE : OP_CV;
        j.cv_o = quo;
        j.cv_k = rem[2:0];
        j.cv_data = cv_data;
      end
      CMD_TICK: j.op = OP_TICK;
      default: j.op = OP_NONE;
    endcase
  end

  assign in_ready = cnt != 2'(QD);
  assign q_valid = cnt != 2'd0;
  assign q_job = q[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) q[wp] <= j;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (in_valid && in_ready) wp <= wp + 1'b1;
      if (q_valid && q_ready) rp <= rp + 1'b1;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule
`default_nettype wire

// ----- sv/fos_back.sv -----
// back end: walks outputs one per cycle while not stalled and emits result words
`timescale 1ns / 1ps
`default_nettype none
module fos_back import fos_pkg::*; #(
  parameter int NUM_OUTPUTS = 12,
  parameter int SLOW_LIMIT = 3
) (
  input wire clk,
  input wire rst,
  input wire q_valid,
  output logic q_ready,
  input job_t q_job,
  output logic out_valid,
  input wire out_ready,
  output logic kind,
  output logic [3:0] servo_index,
  output logic [7:0] servo_position,
  output logic [11:0] pin_levels,
  output logic [11:0] servo_attached,
  output logic last
);
  localparam int NO = NUM_OUTPUTS;

  state_t state, state_next;
  job_t job;
  logic [4:0] idx;
  logic [NFUNCS-1:0] fbits;
  logic [2:0] mode [NO];
  logic [7:0] rate [NO];
  logic [7:0] strt [NO];
  logic [7:0] endv [NO];
  logic [NO-1:0] act, pin, att;
  logic signed [8:0] step [NO];
  logic [7:0] lol [NO];
  logic [7:0] hil [NO];
  logic [9:0] pos [NO];
  logic [3:0] slow;
  logic [1:0] nw;

  logic [11:0] pins12, att12;
  always_comb begin
    pins12 = '0; att12 = '0;
    for (int i = 0; i < NO && i < 12; i++) begin
      pins12[i] = pin[i]; att12[i] = att[i];
    end
  end

  // per-cycle work for output idx
  logic [4:0] i5;
  logic [$clog2(NO+1)-1:0] ii;
  logic in_rng, in_rng1;
  logic [2:0] m;
  logic b;
  logic signed [11:0] ps;
  logic [9:0] psat;
  logic emit_w;
  logic [7:0] emit_p;
  logic done_pkt, skip_pair;

  always_comb begin
    i5 = idx;
    ii = i5 < 5'(NO) ? i5[$bits(ii)-1:0] : '0;
    in_rng = i5 < 5'(NO);
    in_rng1 = (i5 + 5'd1) < 5'(NO);
    m = mode[ii];
    b = job.nb[i5];
    ps = $signed({2'b0, pos[ii]}) + 12'(step[ii]);
    psat = ps < 0 ? 10'd0 : (ps > 12'sd1023 ? 10'd1023 : ps[9:0]);
  end

  // combinational next-state for output work
  logic [NFUNCS-1:0] fbits_n;
  logic [NO-1:0] act_n, pin_n, att_n;
  logic signed [8:0] step_n;
  logic [7:0] lol_n, hil_n;
  logic [9:0] pos_n;
  logic [3:0] slow_n;
  logic wr_o;
  logic [4:0] idx_n;
  logic signed [11:0] p;

  always_comb begin
    fbits_n = fbits; act_n = act; pin_n = pin; att_n = att;
    step_n = step[ii]; lol_n = lol[ii]; hil_n = hil[ii]; pos_n = pos[ii];
    slow_n = slow; wr_o = 1'b0; emit_w = 1'b0; emit_p = '0;
    done_pkt = 1'b0; skip_pair = 1'b0; p = '0;
    idx_n = idx + 5'd1;
    if (job.op == OP_PACKET) begin
      if (b != fbits[i5]) begin
        fbits_n[i5] = b;
        if (!in_rng) done_pkt = 1'b1;
        else begin
          wr_o = 1'b1;
          case (m)
            MODE_ONOFF: begin pin_n[ii] = b; act_n[ii] = 1'b0; end
            MODE_BLINK, MODE_PAIR: begin
              if (b) begin
                act_n[ii] = 1'b1; step_n = $signed({1'b0, rate[ii]});
                lol_n = strt[ii]; hil_n = endv[ii];
                pin_n[ii] = strt[ii] != 8'd0;
                if (m == MODE_PAIR && in_rng1) pin_n[ii+1] = strt[ii] == 8'd0;
                pos_n = '0;
              end else begin
                act_n[ii] = 1'b0; pin_n[ii] = 1'b0;
                if (m == MODE_PAIR && in_rng1) pin_n[ii+1] = 1'b0;
              end
            end
            MODE_SERVO: begin
              if (!act[ii]) begin act_n[ii] = 1'b1; att_n[ii] = 1'b1; end
              step_n = b ? $signed({1'b0, rate[ii]}) : -$signed({1'b0, rate[ii]});
              hil_n = b ? endv[ii] : strt[ii];
            end
            default: act_n[ii] = 1'b0;
          endcase
        end
      end
      if (i5 >= job.hi) done_pkt = 1'b1;
    end else if (job.op == OP_TICK && act[ii]) begin
      case (m)
        MODE_BLINK, MODE_PAIR: begin
          wr_o = 1'b1;
          pos_n = psat;
          if ({2'b0, psat} > {4'b0, hil[ii]}) begin
            if (m == MODE_PAIR && in_rng1) pin_n[ii+1] = lol[ii] != 8'd0;
            lol_n = (lol[ii] != 8'd0) ? 8'd0 : 8'd1;
            pin_n[ii] = lol[ii] == 8'd0;
            pos_n = '0;
          end
          if (m == MODE_PAIR) skip_pair = 1'b1;
        end
        MODE_SERVO: begin
          if (nw < 2'(MAX_SERVO_WRITES)) begin
            if (slow > 4'(SLOW_LIMIT)) begin
              wr_o = 1'b1;
              p = ps;
              if (step[ii] > 0 && p > $signed({4'b0, hil[ii]})) begin
                p = {4'b0, hil[ii]}; act_n[ii] = 1'b0; att_n[ii] = 1'b0;
              end
              if (step[ii] < 0 && p < $signed({4'b0, lol[ii]})) begin
                p = {4'b0, lol[ii]}; act_n[ii] = 1'b0; att_n[ii] = 1'b0;
              end
              pos_n = p < 0 ? 10'd0 : (p > 12'sd1023 ? 10'd1023 : p[9:0]);
              slow_n = '0;
              emit_w = 1'b1;
              emit_p = pos_n > 10'd255 ? 8'd255 : pos_n[7:0];
            end else slow_n = slow + 4'd1;
          end
        end
        default: ;
      endcase
    end
    if (skip_pair) idx_n = idx + 5'd2;
  end

  logic run_done;
  always_comb begin
    run_done = 1'b0;
    if (job.op == OP_PACKET) run_done = done_pkt;
    else if (job.op == OP_TICK) run_done = idx_n >= 5'(NO);
    else run_done = 1'b1;
  end

  // output register
  logic ob_full, stall, ob_load;
  assign stall = ob_full && !out_ready;
  assign out_valid = ob_full;
  assign ob_load = !stall && ((state == ST_RUN && emit_w) || state == ST_STATUS);

  always_comb begin
    state_next = state;
    q_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) state_next = ST_RUN;
      end
      ST_RUN: if (!stall && run_done) state_next = ST_STATUS;
      ST_STATUS: if (!stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fbits <= '0; act <= '0; pin <= '0; att <= '0; slow <= '0;
      ob_full <= 1'b0; nw <= '0; idx <= '0;
      for (int i = 0; i < NO; i++) begin
        mode[i] <= dflt_mode(i); rate[i] <= 8'd1;
        strt[i] <= dflt_start(i); endv[i] <= dflt_end(i);
        step[i] <= '0; lol[i] <= '0; hil[i] <= '0; pos[i] <= '0;
      end
    end else begin
      ob_full <= ob_load || (ob_full && !out_ready);
      case (state)
        ST_IDLE: if (q_valid) begin
          job <= q_job; nw <= '0;
          idx <= (q_job.op == OP_PACKET) ? q_job.lo : 5'd0;
        end
        ST_RUN: if (!stall) begin
          if (job.op == OP_CV) begin
            if (job.cv_o < 8'(NO)) begin
              case (job.cv_k)
                CV_MODE: mode[job.cv_o[$bits(ii)-1:0]] <=
                        job.cv_data > 8'(MODE_MAX) ? MODE_MAX : job.cv_data[2:0];
                CV_RATE: rate[job.cv_o[$bits(ii)-1:0]] <= job.cv_data;
                CV_START: strt[job.cv_o[$bits(ii)-1:0]] <= job.cv_data;
                CV_END: endv[job.cv_o[$bits(ii)-1:0]] <= job.cv_data;
                default: ;
              endcase
            end
          end else if (job.op != OP_NONE) begin
            fbits <= fbits_n; act <= act_n; pin <= pin_n; att <= att_n;
            slow <= slow_n;
            if (wr_o) begin
              step[ii] <= step_n; lol[ii] <= lol_n; hil[ii] <= hil_n;
              pos[ii] <= pos_n;
            end
            idx <= idx_n;
            if (emit_w) begin
              nw <= nw + 2'd1;
              kind <= 1'b0; servo_index <= ii[3:0]; servo_position <= emit_p;
              pin_levels <= '0; servo_attached <= '0; last <= 1'b0;
            end
          end
        end
        ST_STATUS: if (!stall) begin
          kind <= 1'b1; servo_index <= '0; servo_position <= '0;
          pin_levels <= pins12; servo_attached <= att12; last <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- sv/function_output_sequencer_unit.sv -----
// top level of the function output sequencer
// input channel: in_valid/in_ready with cmd, func_byte, ext_byte, cv_number
//   and cv_data; cmd selects function packet, cv write or tick
// output channel: out_valid/out_ready carrying kind, servo_index,
//   servo_position, pin_levels, servo_attached and last
// each word answers with up to three servo writes (tick only) and then
//   one status word with last set
// a two-deep queue sits between the decoder and the output engine, so
//   words are taken while the engine is busy
// the engine visits one output per cycle while the receiver does not stall:
//   a tick walks up to NUM_OUTPUTS outputs, a packet its examined function
//   bits, and a cv write updates one table entry
// a stalled receiver holds the output register and freezes the engine
// reset restores the default output tables and clears all levels
`timescale 1ns / 1ps
`default_nettype none
module function_output_sequencer_unit import fos_pkg::*; #(
  parameter int NUM_OUTPUTS = 12,
  parameter int SLOW_LIMIT = 3
) (
  input wire clk,
  input wire rst,
  input wire in_valid,
  output logic in_ready,
  input wire [1:0] cmd,
  input wire [7:0] func_byte,
  input wire [7:0] ext_byte,
  input wire [7:0] cv_number,
  input wire [7:0] cv_data,
  output logic out_valid,
  input wire out_ready,
  output logic kind,
  output logic [3:0] servo_index,
  output logic [7:0] servo_position,
  output logic [11:0] pin_levels,
  output logic [11:0] servo_attached,
  output logic last
);
  logic q_valid, q_ready;
  job_t q_job;

  fos_front u_front (
    .clk, .rst, .in_valid, .in_ready, .cmd, .func_byte, .ext_byte,
    .cv_number, .cv_data, .q_valid, .q_ready, .q_job
  );

  fos_back #(.NUM_OUTPUTS(NUM_OUTPUTS), .SLOW_LIMIT(SLOW_LIMIT)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_job, .out_valid, .out_ready, .kind,
    .servo_index, .servo_position, .pin_levels, .servo_attached, .last
  );
endmodule
`default_nettype wire
